FILE: rtl/ascc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascc_pkg
// Constants and calendar helpers for the add-seconds calendar clock.
// ----------------------------------------------------------------------------
package ascc_pkg;

  localparam int unsigned SecWidth   = 6;
  localparam int unsigned MinWidth   = 6;
  localparam int unsigned HourWidth  = 5;
  localparam int unsigned DayWidth   = 5;
  localparam int unsigned MonthWidth = 4;
  localparam int unsigned YearWidth  = 14;
  localparam int unsigned AddWidth   = 16;
  localparam int unsigned SumWidth   = AddWidth + 1;

  localparam logic [SecWidth-1:0]   SecReset   = SecWidth'(0);
  localparam logic [MinWidth-1:0]   MinReset   = MinWidth'(0);
  localparam logic [HourWidth-1:0]  HourReset  = HourWidth'(0);
  localparam logic [DayWidth-1:0]   DayReset   = DayWidth'(9);
  localparam logic [MonthWidth-1:0] MonthReset = MonthWidth'(7);
  localparam logic [YearWidth-1:0]  YearReset  = YearWidth'(1982);

  localparam logic [YearWidth-1:0]  MaxYear    = YearWidth'(9999);
  localparam logic [MonthWidth-1:0] LastMonth  = MonthWidth'(12);
  localparam logic [MonthWidth-1:0] Feb        = MonthWidth'(2);
  localparam logic [HourWidth-1:0]  LastHour   = HourWidth'(23);
  localparam logic [MinWidth-1:0]   LastMin    = MinWidth'(59);
  localparam logic [SecWidth-1:0]   LastSec    = SecWidth'(59);

  // x / 60 for x below 2^16 + 60: (x >> 2) / 15 by reciprocal 34953 / 2^19
  function automatic logic [10:0] div60(input logic [SumWidth-1:0] x);
    logic [30:0] prod;
    prod = 31'(x[SumWidth-1:2]) * 31'(34953);
    return prod[29:19];
  endfunction

  // leap year by the 4/100/400 rule; y % 25 by reciprocal 5243 / 2^17
  function automatic logic is_leap(input logic [YearWidth-1:0] y);
    logic [26:0] prod;
    logic [9:0]  q25;
    logic [13:0] r25;
    prod = 27'(y) * 27'(5243);
    q25  = prod[26:17];
    r25  = y - 14'(q25) * 14'd25;
    return (y[1:0] == 2'b00) && ((r25 != 14'd0) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayWidth-1:0] days_in(input logic [MonthWidth-1:0] m,
                                                  input logic [YearWidth-1:0] y);
    logic [DayWidth-1:0] d;
    unique case (m)
      4'd2:                     d = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/add_seconds_calendar_clock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// add_seconds_calendar_clock_top
// Time of day and Gregorian date; each word adds up to 65535 seconds.
// ----------------------------------------------------------------------------
// result path: input register, then the clock registers
// throughput: one word per cycle unless out_stall holds the result, set by the
// update of the clock registers, which also serve as the result register
// reset (rst, synchronous): time 00:00:00, date 1982-07-09, pipeline empty
// the clock saturates at 9999-12-31 23:59:59 and flags overflow for that word
module add_seconds_calendar_clock_top
  import ascc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [AddWidth-1:0]   elapsed_seconds,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [YearWidth-1:0]  year,
  output logic [MonthWidth-1:0] month,
  output logic [DayWidth-1:0]   day,
  output logic [HourWidth-1:0]  hour,
  output logic [MinWidth-1:0]   minute,
  output logic [SecWidth-1:0]   second,
  output logic                  overflow
);

  logic                  in_reg_valid;
  logic [AddWidth-1:0]   in_reg;
  logic                  advance;
  logic                  update;

  logic [SumWidth-1:0]   sec_sum;
  logic [10:0]           q_min;
  logic [11:0]           min_sum;
  logic [4:0]            q_hour;
  logic [5:0]            hour_sum;
  logic                  day_carry;

  logic [YearWidth-1:0]  year_next;
  logic [MonthWidth-1:0] month_next;
  logic [DayWidth-1:0]   day_next;
  logic [HourWidth-1:0]  hour_next;
  logic [MinWidth-1:0]   minute_next;
  logic [SecWidth-1:0]   second_next;
  logic                  overflow_next;

  // result register frees up when empty or taken this cycle
  assign advance  = !out_valid || !out_stall;
  assign update   = advance && in_reg_valid;
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_reg_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= elapsed_seconds;
    end
  end

  // carry chain: seconds -> minutes -> hours -> at most one day
  always_comb begin
    sec_sum     = SumWidth'(second) + SumWidth'(in_reg);
    q_min       = div60(sec_sum);
    second_next = SecWidth'(sec_sum - SumWidth'(q_min) * SumWidth'(60));
    min_sum     = 12'(minute) + 12'(q_min);
    q_hour      = 5'(div60(SumWidth'(min_sum)));
    minute_next = MinWidth'(min_sum - 12'(q_hour) * 12'd60);
    hour_sum    = 6'(hour) + 6'(q_hour);
    day_carry   = hour_sum >= 6'd24;
    hour_next   = day_carry ? HourWidth'(hour_sum - 6'd24) : HourWidth'(hour_sum);

    year_next     = year;
    month_next    = month;
    day_next      = day;
    overflow_next = 1'b0;
    if (day_carry) begin
      priority if (day < days_in(month, year)) begin
        day_next = day + DayWidth'(1);
      end else if (month < LastMonth) begin
        day_next   = DayWidth'(1);
        month_next = month + MonthWidth'(1);
      end else if (year >= MaxYear) begin
        // saturate at the last representable second
        overflow_next = 1'b1;
        hour_next     = LastHour;
        minute_next   = LastMin;
        second_next   = LastSec;
      end else begin
        day_next   = DayWidth'(1);
        month_next = MonthWidth'(1);
        year_next  = year + YearWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year     <= YearReset;
      month    <= MonthReset;
      day      <= DayReset;
      hour     <= HourReset;
      minute   <= MinReset;
      second   <= SecReset;
      overflow <= 1'b0;
    end else if (update) begin
      year     <= year_next;
      month    <= month_next;
      day      <= day_next;
      hour     <= hour_next;
      minute   <= minute_next;
      second   <= second_next;
      overflow <= overflow_next;
    end
  end

endmodule
